// File: rtl/fss_pkg.sv
// Package for the fuzzy subsequence scorer: sizes, codes, character constants, a case-folding helper.
package fss_pkg;

  localparam int unsigned MaxQueryDef     = 64;
  localparam int unsigned MaxCandidateDef = 4096;

  localparam int unsigned SymW   = 8;
  localparam int unsigned ScoreW = 17;
  localparam int unsigned FracW  = 16;

  localparam logic [ScoreW-1:0] ScoreOne = ScoreW'(1 << FracW);

  localparam logic [SymW-1:0] ChSlash = 8'h2F;
  localparam logic [SymW-1:0] ChDash  = 8'h2D;
  localparam logic [SymW-1:0] ChUnder = 8'h5F;
  localparam logic [SymW-1:0] ChSpace = 8'h20;
  localparam logic [SymW-1:0] ChUpA   = 8'h41;
  localparam logic [SymW-1:0] ChUpZ   = 8'h5A;

  // tenths awarded per matched character
  localparam logic [3:0] TenBase  = 4'd1;
  localparam logic [3:0] TenCase  = 4'd1;
  localparam logic [3:0] TenAdj   = 4'd8;
  localparam logic [3:0] TenSep   = 4'd7;

  typedef enum logic [2:0] {
    ST_FUZZY    = 3'd0,
    ST_EXACT    = 3'd1,
    ST_LASTSEG  = 3'd2,
    ST_NOMATCH  = 3'd3,
    ST_INVALID  = 3'd4
  } fss_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MATCH,
    S_CHECK,
    S_SEG_RD,
    S_SEG_CMP,
    S_MUL_A,
    S_MUL_B,
    S_DEN,
    S_DIV_GO,
    S_DIV,
    S_EMIT
  } fss_state_e;

  function automatic logic [SymW-1:0] fold_case(input logic [SymW-1:0] c);
    logic [SymW-1:0] r;
    r = c;
    if (c >= ChUpA && c <= ChUpZ) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// File: rtl/fuzzy_subsequence_score.sv
// Top level of the fuzzy subsequence scorer: query store, match sequencer, result register.
//
// Usage: load a query one beat at a time with mode_i = 0 (last_i on its final
// character), then stream candidate paths with mode_i = 1, last_i marking the
// end of each. Query characters are matched greedily, in order, ignoring ASCII
// case; each match earns tenths (base 1, +1 same case, +8 straight after the
// previous match, at the start or after '/', else +7 after '-', '_' or space).
// One result beat per candidate: an exact match or a query equal to the last
// path segment gives 1.0 (65536 in Q16); a query not found in full gives
// status 3, score 0; otherwise the score is floor(T*(Q+S)*65536 / (20*Q*S)).
// Empty or too-long queries, overlong candidates and queries not shorter than
// the candidate, bar an exact match, give status 4. A query beat starts a new
// query if the previous one was closed, and drops any candidate in progress.
// A candidate beat that is not the last is accepted, then updates the match
// state from a registered query-store read. The final beat goes on to a check
// state, then a last-segment scan of up to Q+1 compared characters (a tail
// read, then a compare, for each), for a fuzzy score the set-up (products,
// denominator, divider start) and the shared restoring divider (39 numerator
// bits at the default sizes) with its done flag, then a load of the output
// register once it is free. The input is not ready while an item is in work;
// the output register lets the next item in while a result beat waits.
module fuzzy_subsequence_score
  import fss_pkg::*;
#(
  parameter int unsigned MAX_QUERY     = MaxQueryDef,
  parameter int unsigned MAX_CANDIDATE = MaxCandidateDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic [SymW-1:0]   symbol_i,
  input  logic              last_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ScoreW-1:0] score_o,
  output logic [2:0]        status_o
);

  localparam int unsigned QlW       = $clog2(MAX_QUERY + 1);
  localparam int unsigned QaW       = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
  localparam int unsigned TailDepth = MAX_QUERY + 1;
  localparam int unsigned TaW       = $clog2(TailDepth);
  localparam int unsigned ClW       = $clog2(MAX_CANDIDATE + 2);
  localparam int unsigned TenW      = $clog2(10 * MAX_QUERY + 1);
  localparam int unsigned SumW      = $clog2(MAX_QUERY + MAX_CANDIDATE + 2);
  localparam int unsigned AW        = TenW + SumW;
  localparam int unsigned NumW      = AW + FracW;
  localparam int unsigned BW        = QlW + ClW;
  localparam int unsigned DenW      = BW + 5;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  fss_state_e state_q, state_d;

  // query bookkeeping
  logic [QlW-1:0]  ql_q, ql_d;
  logic            too_long_q, too_long_d;
  logic            closed_q, closed_d;

  // per-candidate match state
  logic [QlW-1:0]  qpos_q, qpos_d;
  logic [ClW-1:0]  cl_q, cl_d;
  logic [TenW-1:0] tenths_q, tenths_d;
  logic [SymW-1:0] prev_q, prev_d;
  logic            adj_q, adj_d;
  logic            eq_q, eq_d;
  logic [TaW-1:0]  tidx_q, tidx_d;    // candidate length modulo tail depth

  // latched beat
  logic [SymW-1:0] sym_q;
  logic            last_q;

  // last-segment scan
  logic [QlW-1:0]  segk_q, segk_d;
  logic [TaW-1:0]  tptr_q, tptr_d;

  // score arithmetic
  logic [AW-1:0]   prod_a_q, prod_a_d;
  logic [BW-1:0]   prod_b_q, prod_b_d;
  logic [DenW-1:0] den_q, den_d;

  // pending result and output register
  logic [ScoreW-1:0] res_score_q, res_score_d;
  fss_status_e       res_status_q, res_status_d;
  logic              out_valid_q, out_valid_d;
  logic [ScoreW-1:0] out_score_q;
  fss_status_e       out_status_q;
  logic              out_load;

  // memories
  logic [SymW-1:0] qmem [MAX_QUERY];
  logic [SymW-1:0] tmem [TailDepth];
  logic [SymW-1:0] rd_pos_q, rd_qp_q, rd_tail_q;
  logic            q_we, t_we;
  logic [QaW-1:0]  q_waddr, q_raddr_a;

  // divider
  logic            div_start, div_busy, div_done;
  logic [NumW-1:0] div_quot;

  logic in_acc;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // ---------------------------------------------------------------------------
  // Combinational helpers
  // ---------------------------------------------------------------------------
  logic [QlW-1:0]  qbase;
  logic [3:0]      tval;
  logic            qp_hit, in_range, ch_match;
  logic [TaW:0]    seg_start;
  logic [SymW-1:0] seg_exp;
  logic [ScoreW-1:0] quot_clamped;

  assign qbase    = closed_q ? '0 : ql_q;
  assign in_range = cl_q < ClW'(MAX_CANDIDATE);
  assign qp_hit   = qpos_q < ql_q;
  assign ch_match = fold_case(rd_qp_q) == fold_case(sym_q);

  always_comb begin
    tval = TenBase;
    if (rd_qp_q == sym_q) begin
      tval = tval + TenCase;
    end
    if (adj_q || prev_q == ChSlash) begin
      tval = tval + TenAdj;
    end else if (prev_q == ChDash || prev_q == ChUnder || prev_q == ChSpace) begin
      tval = tval + TenSep;
    end
  end

  // first tail entry to check: the one just before the last Q characters
  always_comb begin
    seg_start = (TaW+1)'(tidx_q) + (TaW+1)'(TailDepth) - (TaW+1)'(ql_q) - (TaW+1)'(1);
    if (seg_start >= (TaW+1)'(TailDepth)) begin
      seg_start = seg_start - (TaW+1)'(TailDepth);
    end
  end

  assign seg_exp = (segk_q == '0) ? ChSlash : rd_pos_q;

  assign quot_clamped = (div_quot > NumW'(ScoreOne)) ? ScoreOne : div_quot[ScoreW-1:0];

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && mode_i) begin
          state_d = S_MATCH;
        end
      end
      S_MATCH: state_d = last_q ? S_CHECK : S_IDLE;
      S_CHECK: begin
        if (ql_q == '0 || too_long_q || cl_q > ClW'(MAX_CANDIDATE)) begin
          state_d = S_EMIT;
        end else if (eq_q && ClW'(ql_q) == cl_q) begin
          state_d = S_EMIT;
        end else if (ClW'(ql_q) >= cl_q) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_SEG_RD;
        end
      end
      S_SEG_RD: state_d = S_SEG_CMP;
      S_SEG_CMP: begin
        if (rd_tail_q != seg_exp) begin
          state_d = qp_hit ? S_EMIT : S_MUL_A;
        end else if (segk_q == ql_q) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_SEG_RD;
        end
      end
      S_MUL_A:  state_d = S_MUL_B;
      S_MUL_B:  state_d = S_DEN;
      S_DEN:    state_d = S_DIV_GO;
      S_DIV_GO: state_d = S_DIV;
      S_DIV: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath and outputs of the sequencer
  // ---------------------------------------------------------------------------
  assign out_load  = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign div_start = (state_q == S_DIV_GO);

  always_comb begin
    ql_d         = ql_q;
    too_long_d   = too_long_q;
    closed_d     = closed_q;
    qpos_d       = qpos_q;
    cl_d         = cl_q;
    tenths_d     = tenths_q;
    prev_d       = prev_q;
    adj_d        = adj_q;
    eq_d         = eq_q;
    tidx_d       = tidx_q;
    segk_d       = segk_q;
    tptr_d       = tptr_q;
    prod_a_d     = prod_a_q;
    prod_b_d     = prod_b_q;
    den_d        = den_q;
    res_score_d  = res_score_q;
    res_status_d = res_status_q;
    q_we         = 1'b0;
    t_we         = 1'b0;
    q_waddr      = QaW'(qbase);
    q_raddr_a    = QaW'(cl_q);
    out_valid_d  = out_valid_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_acc && !mode_i) begin
          // query beat: restart if the last query was closed
          if (closed_q) begin
            too_long_d = 1'b0;
          end
          if (qbase < QlW'(MAX_QUERY)) begin
            q_we = 1'b1;
            ql_d = qbase + 1'b1;
          end else begin
            ql_d       = qbase;
            too_long_d = 1'b1;
          end
          closed_d = last_i;
          qpos_d   = '0;
          cl_d     = '0;
          tenths_d = '0;
          prev_d   = '0;
          adj_d    = 1'b1;
          eq_d     = 1'b1;
          tidx_d   = '0;
        end
      end
      S_MATCH: begin
        if (in_range) begin
          t_we   = 1'b1;
          tidx_d = (tidx_q == TaW'(TailDepth - 1)) ? '0 : tidx_q + 1'b1;
          if (!(ClW'(ql_q) > cl_q && rd_pos_q == sym_q)) begin
            eq_d = 1'b0;
          end
          if (qp_hit && ch_match) begin
            tenths_d = tenths_q + TenW'(tval);
            qpos_d   = qpos_q + 1'b1;
            adj_d    = 1'b1;
          end else begin
            adj_d = 1'b0;
          end
          prev_d = sym_q;
          cl_d   = cl_q + 1'b1;
        end else begin
          cl_d = ClW'(MAX_CANDIDATE + 1);
        end
      end
      S_CHECK: begin
        res_score_d  = '0;
        res_status_d = ST_INVALID;
        if (ql_q == '0 || too_long_q || cl_q > ClW'(MAX_CANDIDATE)) begin
          res_status_d = ST_INVALID;
        end else if (eq_q && ClW'(ql_q) == cl_q) begin
          res_score_d  = ScoreOne;
          res_status_d = ST_EXACT;
        end
        segk_d = '0;
        tptr_d = seg_start[TaW-1:0];
      end
      S_SEG_RD: begin
        q_raddr_a = QaW'(segk_q - 1'b1);
      end
      S_SEG_CMP: begin
        if (rd_tail_q != seg_exp) begin
          res_score_d  = '0;
          res_status_d = ST_NOMATCH;
        end else if (segk_q == ql_q) begin
          res_score_d  = ScoreOne;
          res_status_d = ST_LASTSEG;
        end else begin
          segk_d = segk_q + 1'b1;
          tptr_d = (tptr_q == TaW'(TailDepth - 1)) ? '0 : tptr_q + 1'b1;
        end
      end
      S_MUL_A: begin
        prod_a_d = AW'(tenths_q) * AW'(SumW'(ql_q) + SumW'(cl_q));
      end
      S_MUL_B: begin
        prod_b_d = BW'(ql_q) * BW'(cl_q);
      end
      S_DEN: begin
        // 20 * Q * S as two shifted copies
        den_d = (DenW'(prod_b_q) << 4) + (DenW'(prod_b_q) << 2);
      end
      S_DIV_GO: begin
      end
      S_DIV: begin
        if (div_done) begin
          res_score_d  = quot_clamped;
          res_status_d = ST_FUZZY;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          qpos_d      = '0;
          cl_d        = '0;
          tenths_d    = '0;
          prev_d      = '0;
          adj_d       = 1'b1;
          eq_d        = 1'b1;
          tidx_d      = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ql_q        <= '0;
      too_long_q  <= 1'b0;
      closed_q    <= 1'b0;
      qpos_q      <= '0;
      cl_q        <= '0;
      tenths_q    <= '0;
      prev_q      <= '0;
      adj_q       <= 1'b1;
      eq_q        <= 1'b1;
      tidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ql_q        <= ql_d;
      too_long_q  <= too_long_d;
      closed_q    <= closed_d;
      qpos_q      <= qpos_d;
      cl_q        <= cl_d;
      tenths_q    <= tenths_d;
      prev_q      <= prev_d;
      adj_q       <= adj_d;
      eq_q        <= eq_d;
      tidx_q      <= tidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
    end
    segk_q       <= segk_d;
    tptr_q       <= tptr_d;
    prod_a_q     <= prod_a_d;
    prod_b_q     <= prod_b_d;
    den_q        <= den_d;
    res_score_q  <= res_score_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_score_q  <= res_score_q;
      out_status_q <= res_status_q;
    end
  end

  // query store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (q_we) begin
      qmem[q_waddr] <= symbol_i;
    end
    rd_pos_q <= qmem[q_raddr_a];
    rd_qp_q  <= qmem[QaW'(qpos_q)];
  end

  // candidate tail window: circular, last MAX_QUERY+1 characters
  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tmem[tidx_q] <= sym_q;
    end
    rd_tail_q <= tmem[tptr_q];
  end

  // ---------------------------------------------------------------------------
  // Shared divider
  // ---------------------------------------------------------------------------
  fss_div #(
    .NUM_W (NumW),
    .DEN_W (DenW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ({prod_a_q, FracW'(0)}),
    .den_i   (den_q),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign score_o     = out_score_q;
  assign status_o    = out_status_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_qpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qpos_q <= ql_q)
    else $error("query position beyond query length");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> state_q == S_DIV)
    else $error("divider busy outside divide state");

  a_full_score_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (res_status_q == ST_EXACT || res_status_q == ST_LASTSEG)
      |=> score_o == ScoreOne)
    else $error("exact or last-segment result without full score");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && (res_status_q == ST_INVALID || res_status_q == ST_NOMATCH)
      |=> score_o == '0)
    else $error("invalid or unmatched result with non-zero score");

endmodule

// File: rtl/fss_div.sv
// Iterative restoring divider, one quotient bit per cycle.
module fss_div
  import fss_pkg::*;
#(
  parameter int unsigned NUM_W = 39,
  parameter int unsigned DEN_W = 25
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NUM_W + 1);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [NUM_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q, den_q;

  logic [DEN_W:0]   shifted;
  logic [DEN_W+1:0] trial;
  logic             take;

  assign shifted = {rem_q, acc_q[NUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, den_q};
  assign take    = ~trial[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CntW'(NUM_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= take ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      acc_q <= {acc_q[NUM_W-2:0], take};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = acc_q;

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

  a_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> den_q != '0)
    else $error("divide by zero");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> rem_q < den_q)
    else $error("remainder not below divisor");

endmodule
